// File: src/upm_pkg.sv
// ----------------------------------------------------------------------------
// upm_pkg
// Shared types and constants for the unsharp mask core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package upm_pkg;

  localparam int unsigned KERNEL_SIZE = 5;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned PRE_ROWS = 8;
  localparam int unsigned ORIG_ROWS = 4;

  // Register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TAP_OUTER    = 3'd2;
  localparam logic [2:0] REG_TAP_NEAR     = 3'd3;
  localparam logic [2:0] REG_TAP_CENTER   = 3'd4;
  localparam logic [2:0] REG_GAIN         = 3'd5;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic       accept;  // input transaction this cycle
    logic       clear;   // clear accumulators
    logic       issue;   // issue one window read
    logic [2:0] tx;      // window column 0..4
    logic [2:0] ty;      // window row 0..4
    logic       calc;    // blur, mask and gain product
    logic       load;    // load output register, advance output position
  } upm_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic emit;      // last accepted item produces a result
    logic out_free;  // output register can take a result
  } upm_sts_t;

endpackage
`default_nettype wire

// File: src/upm_ctrl.sv
// ----------------------------------------------------------------------------
// upm_ctrl
// Sequencer: accepts an item and, if it yields a result, walks the 5x5 window and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module upm_ctrl
  import upm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire upm_sts_t sts,
  output upm_cmd_t      cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_TAPS, S_ACC, S_CALC, S_OUT} state_t;

  state_t     state_r;
  logic [2:0] tx_r;
  logic [2:0] ty_r;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    cmd        = '0;
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.clear  = (state_r == S_CHECK);
    cmd.issue  = (state_r == S_TAPS);
    cmd.tx     = tx_r;
    cmd.ty     = ty_r;
    cmd.calc   = (state_r == S_CALC);
    cmd.load   = (state_r == S_OUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tx_r    <= '0;
      ty_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_CHECK;
        end
        S_CHECK: begin
          tx_r    <= '0;
          ty_r    <= '0;
          state_r <= sts.emit ? S_TAPS : S_IDLE;
        end
        S_TAPS: begin
          if (tx_r == 3'(KERNEL_SIZE - 1)) begin
            tx_r <= '0;
            if (ty_r == 3'(KERNEL_SIZE - 1)) state_r <= S_ACC;
            else ty_r <= ty_r + 3'd1;
          end else begin
            tx_r <= tx_r + 3'd1;
          end
        end
        S_ACC:  state_r <= S_CALC;
        S_CALC: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/upm_datapath.sv
// ----------------------------------------------------------------------------
// upm_datapath
// Line stores, frame bookkeeping, tap MAC, mask and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module upm_datapath
  import upm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire upm_cmd_t    cmd,
  output upm_sts_t         sts,
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tlast
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  // Configuration
  logic [10:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [7:0]  tap_outer_r, tap_near_r, tap_center_r;
  logic [4:0]  gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd640;
      frame_height_r <= 13'd480;
      tap_outer_r    <= 8'd14;
      tap_near_r     <= 8'd62;
      tap_center_r   <= 8'd104;
      gain_r         <= 5'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_TAP_OUTER:    tap_outer_r    <= cfg_data[7:0];
        REG_TAP_NEAR:     tap_near_r     <= cfg_data[7:0];
        REG_TAP_CENTER:   tap_center_r   <= cfg_data[7:0];
        REG_GAIN:         gain_r         <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Frame bookkeeping
  logic [13:0] lat_w_r;
  logic [12:0] lat_h_r;
  logic [13:0] col_r, out_col_r;
  logic [12:0] row_r, out_row_r;
  logic [14:0] pend_r;
  logic        active_r, draining_r, emit_r;

  logic [13:0] w_nxt, col_eff, col_inc;
  logic [12:0] h_nxt, row_eff, row_inc;
  logic [14:0] pend_eff, pend_inc;
  logic        start;

  always_comb begin
    w_nxt = {3'd0, frame_width_r};
    if (w_nxt < 14'd5) w_nxt = 14'd5;
    if (w_nxt > MAXW) w_nxt = MAXW;
    h_nxt = frame_height_r;
    if (h_nxt < 13'd5) h_nxt = 13'd5;
    if (h_nxt > 13'(HEIGHT_LIMIT)) h_nxt = 13'(HEIGHT_LIMIT);
    start    = !active_r;
    col_eff  = start ? 14'd0 : col_r;
    row_eff  = start ? 13'd0 : row_r;
    pend_eff = start ? 15'd0 : pend_r;
    pend_inc = pend_eff + 15'd1;
    col_inc  = col_eff + 14'd1;
    row_inc  = row_eff + 13'd1;
  end

  logic [13:0] w_use;
  logic [12:0] h_use;
  assign w_use = start ? w_nxt : lat_w_r;
  assign h_use = start ? h_nxt : lat_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_w_r    <= 14'd5;
      lat_h_r    <= 13'd5;
      col_r      <= '0;
      row_r      <= '0;
      pend_r     <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      active_r   <= 1'b0;
      draining_r <= 1'b0;
      emit_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_tuser == ACT_FLUSH) begin
          emit_r <= draining_r && (pend_r != 15'd0);
          if (draining_r && (pend_r != 15'd0)) pend_r <= pend_r - 15'd1;
        end else begin
          if (start) begin
            lat_w_r    <= w_nxt;
            lat_h_r    <= h_nxt;
            out_col_r  <= '0;
            out_row_r  <= '0;
            draining_r <= 1'b0;
          end
          active_r <= 1'b1;
          if (col_inc >= w_use) begin
            col_r <= '0;
            if (row_inc >= h_use) begin
              row_r      <= '0;
              active_r   <= 1'b0;
              draining_r <= 1'b1;
            end else begin
              row_r <= row_inc;
            end
          end else begin
            col_r <= col_inc;
          end
          if ({1'b0, pend_inc} > ({1'b0, w_use, 1'b0} + 16'd2)) begin
            emit_r <= 1'b1;
            pend_r <= pend_eff;
          end else begin
            emit_r <= 1'b0;
            pend_r <= pend_inc;
          end
        end
      end
      if (cmd.load) begin
        if (out_col_r + 14'd1 >= lat_w_r) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 13'd1;
        end else begin
          out_col_r <= out_col_r + 14'd1;
        end
      end
    end
  end

  // Line stores
  logic [23:0] blur_mem [PRE_ROWS][MAX_WIDTH];
  logic [23:0] orig_mem [ORIG_ROWS][MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_tuser == ACT_PIXEL) begin
      blur_mem[row_eff[2:0]][col_eff[CW-1:0]] <= in_tdata[47:24];
      orig_mem[row_eff[1:0]][col_eff[CW-1:0]] <= in_tdata[23:0];
    end
  end

  // Window address with reflect-101 borders
  logic signed [15:0] rs, cs;
  logic [2:0]  rd_row;
  logic [13:0] rd_col;
  logic [7:0]  wy, wx;

  always_comb begin
    rs = $signed({3'd0, out_row_r}) + $signed({13'd0, cmd.ty}) - 16'sd2;
    if (rs < 0) rs = -rs;
    if (rs >= $signed({3'd0, lat_h_r})) rs = $signed({2'd0, lat_h_r, 1'b0}) - 16'sd2 - rs;
    if (rs < 0) rs = '0;
    rd_row = rs[2:0];
    cs = $signed({2'd0, out_col_r}) + $signed({13'd0, cmd.tx}) - 16'sd2;
    if (cs < 0) cs = -cs;
    if (cs >= $signed({2'd0, lat_w_r})) cs = $signed({1'd0, lat_w_r, 1'b0}) - 16'sd2 - cs;
    if (cs < 0) cs = '0;
    if (cs > $signed({2'd0, MAXW}) - 16'sd1) cs = $signed({2'd0, MAXW}) - 16'sd1;
    rd_col = cs[13:0];
    case (cmd.ty)
      3'd2:        wy = tap_center_r;
      3'd1, 3'd3:  wy = tap_near_r;
      default:     wy = tap_outer_r;
    endcase
    case (cmd.tx)
      3'd2:        wx = tap_center_r;
      3'd1, 3'd3:  wx = tap_near_r;
      default:     wx = tap_outer_r;
    endcase
  end

  logic [23:0] pix_r, orig_r;
  logic [15:0] wt_r;
  logic        mac_v_r;
  logic [28:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pix_r  <= blur_mem[rd_row][rd_col[CW-1:0]];
      orig_r <= orig_mem[out_row_r[1:0]][out_col_r[CW-1:0]];
      wt_r   <= wy * wx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mac_v_r <= 1'b0;
    else        mac_v_r <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.clear) acc_r[ch] <= '0;
      else if (mac_v_r) acc_r[ch] <= acc_r[ch] + 29'(wt_r) * 29'(pix_r[ch*8 +: 8]);
    end
  end

  // Mask and gain
  logic [12:0] prod_r [3];
  logic [7:0]  o_r [3];
  logic        last_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [13:0] bl;
        logic [7:0]  b8, o8, m8;
        bl = 14'((30'(acc_r[ch]) + 30'd32768) >> 16);
        b8 = (bl > 14'd255) ? 8'd255 : bl[7:0];
        o8 = orig_r[ch*8 +: 8];
        m8 = (o8 > b8) ? o8 - b8 : 8'd0;
        prod_r[ch] <= m8 * gain_r;
        o_r[ch]    <= o8;
      end
      last_r <= (out_row_r == lat_h_r - 13'd1) && (out_col_r == lat_w_r - 14'd1);
    end
  end

  // Output register
  logic [23:0] res;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [11:0] v;
      v = {4'd0, o_r[ch]} + 12'((13'(prod_r[ch]) + 13'd2) >> 2);
      res[ch*8 +: 8] = (v > 12'd255) ? 8'd255 : v[7:0];
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata <= res;
      out_tlast <= last_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.emit     = emit_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule
`default_nettype wire

// File: src/unsharp_mask_gaussian5x5_core.sv
// ----------------------------------------------------------------------------
// unsharp_mask_gaussian5x5_core
// Streaming 5x5 Gaussian unsharp mask, three 8-bit channels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, each with an original and a preprocessed
// value. The preprocessed plane is blurred with a separable 5x5 kernel
// (reflect-101 borders, Q8 taps, rounded half up, saturated) and the result
// is orig + round(max(orig - blur, 0) * gain / 4), saturated to 255. Results
// trail the input by 2*W+2 pixels; flush transactions (tuser = 1) drain the
// tail once a frame is complete. W and H are latched on a frame's first
// pixel. A transaction that yields no result passes only the idle and
// check states; one that yields a result also makes 25 window reads, one per
// cycle through the single read port of the preprocessed line store, and
// passes the MAC, mask and output stages. The next transaction is taken while a
// result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module unsharp_mask_gaussian5x5_core
  import upm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: pre_b, pre_g, pre_r, orig_b, orig_g, orig_r (8 bits each)
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,
  // tuser: action (0 pixel, 1 flush)
  input  wire logic        in_tuser,
  // tdata: sharp_b, sharp_g, sharp_r; tlast: frame_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  output logic             out_tlast,
  // register write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  upm_cmd_t cmd;
  upm_sts_t sts;

  assign cfg_ready = 1'b1;

  upm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  upm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
